// ----- rtl/atrr_pkg.sv -----
// ----------------------------------------------------------------------------
// atrr_pkg - shared types and constants for the angular touch receptor ring
// Sequencer states, register indexes, CORDIC widths and the arctangent table.
// ----------------------------------------------------------------------------
package atrr_pkg;

  localparam int CoordW    = 16;  // Q8.8 contact coordinates
  localparam int TurnW     = 16;  // turn fraction, 1/65536 turn per LSB
  localparam int ResW      = 6;   // resolution register
  localparam int TolW      = 15;  // boundary tolerance register
  localparam int MaskW     = 32;  // receptor mask
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 15;
  localparam int CordicN   = 16;  // rotation steps
  localparam int StepW     = 4;
  localparam int VecW      = 19;  // holds negated input times CORDIC gain
  localparam int AngW      = 18;  // angle accumulator, signed
  localparam int AtanW     = 14;
  localparam int ProdW     = TurnW + ResW;

  localparam logic [CfgIdxW-1:0] REG_RESOLUTION = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE  = 1'd1;

  localparam logic [ResW-1:0] RES_RESET = 6'd8;
  localparam logic [TolW-1:0] TOL_RESET = 15'd3277;

  localparam logic [AngW-1:0] HALF_TURN = 18'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_MAP,
    ST_UPDATE
  } state_t;

  // atan(2^-i) in 1/65536 turn
  function automatic logic [AtanW-1:0] atan_turn(input logic [StepW-1:0] i);
    logic [AtanW-1:0] a;
    unique case (i)
      4'd0:    a = 14'd8192;
      4'd1:    a = 14'd4836;
      4'd2:    a = 14'd2555;
      4'd3:    a = 14'd1297;
      4'd4:    a = 14'd651;
      4'd5:    a = 14'd326;
      4'd6:    a = 14'd163;
      4'd7:    a = 14'd81;
      4'd8:    a = 14'd41;
      4'd9:    a = 14'd20;
      4'd10:   a = 14'd10;
      4'd11:   a = 14'd5;
      4'd12:   a = 14'd3;
      4'd13:   a = 14'd1;
      4'd14:   a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/angular_touch_receptor_ring.sv -----
// ----------------------------------------------------------------------------
// angular_touch_receptor_ring - contact list to receptor bit mask
// Maps each touching contact to a receptor by angle and ORs it into a mask.
// ----------------------------------------------------------------------------
// One request is one contact. A touching contact goes through the accept
// cycle, 16 CORDIC rotation steps plus their done cycle on one shared
// add/shift unit, the turn * resolution product and the mask update. A
// contact that is not touching skips the CORDIC. The block takes no request
// while it works on one. The mask is emitted on a contact marked last; it
// sits in an output register, so the next list can start while the result
// waits, and a later last contact stalls in the update cycle only while the
// previous result is still untaken. Resolution 0 acts as 1, values above
// MAX_RECEPTORS (or 32) saturate. Configuration must be written only while
// idle; the block itself does not enforce it.
module angular_touch_receptor_ring #(
  parameter int MAX_RECEPTORS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [atrr_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [atrr_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                touching,
  input  logic signed [atrr_pkg::CoordW-1:0]  point_x,
  input  logic signed [atrr_pkg::CoordW-1:0]  point_y,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [atrr_pkg::MaskW-1:0]          receptor_mask
);

  // receptors actually usable: capped by the mask width
  localparam int EffMax = (MAX_RECEPTORS < atrr_pkg::MaskW) ? MAX_RECEPTORS
                                                            : atrr_pkg::MaskW;

  atrr_pkg::state_t state, state_next;

  logic [atrr_pkg::ResW-1:0]   resolution;
  logic [atrr_pkg::TolW-1:0]   boundary_tolerance;
  logic [atrr_pkg::MaskW-1:0]  accumulated_mask;
  logic                        touching_q;
  logic                        last_q;
  logic [atrr_pkg::ProdW-1:0]  prod;

  logic                        cordic_start;
  logic                        cordic_done;
  logic [atrr_pkg::TurnW-1:0]  turn;

  logic [atrr_pkg::ResW-1:0]   eff;
  logic [atrr_pkg::ResW-1:0]   idx;
  logic [atrr_pkg::ResW-1:0]   idx_prev;
  logic [atrr_pkg::ResW-1:0]   idx_next;
  logic [atrr_pkg::TurnW-1:0]  rem;
  logic [atrr_pkg::TurnW:0]    upper_edge;
  logic [atrr_pkg::MaskW-1:0]  hit;
  logic [atrr_pkg::MaskW-1:0]  mask_new;
  logic                        out_free;
  logic                        emit;
  logic                        acc_load;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution         <= atrr_pkg::RES_RESET;
      boundary_tolerance <= atrr_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atrr_pkg::REG_RESOLUTION: resolution <= cfg_data[atrr_pkg::ResW-1:0];
        atrr_pkg::REG_TOLERANCE:  boundary_tolerance <= cfg_data[atrr_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // shared angle unit
  atrr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x     (point_x),
    .y     (point_y),
    .done  (cordic_done),
    .turn  (turn)
  );

  // effective receptor count
  always_comb begin
    if (resolution == '0) begin
      eff = atrr_pkg::ResW'(1);
    end else if (resolution > atrr_pkg::ResW'(EffMax)) begin
      eff = atrr_pkg::ResW'(EffMax);
    end else begin
      eff = resolution;
    end
  end

  // slice index and fraction; turn < 1 so index < eff already
  assign idx        = prod[atrr_pkg::ProdW-1:atrr_pkg::TurnW];
  assign rem        = prod[atrr_pkg::TurnW-1:0];
  assign idx_prev   = (idx == '0) ? eff - 1'b1 : idx - 1'b1;
  assign idx_next   = (idx + 1'b1 == eff) ? '0 : idx + 1'b1;
  assign upper_edge = 17'h10000 - (atrr_pkg::TurnW+1)'(boundary_tolerance);

  always_comb begin
    hit = '0;
    if (touching_q) begin
      hit[idx[4:0]] = 1'b1;
      if (rem < atrr_pkg::TurnW'(boundary_tolerance)) begin
        hit[idx_prev[4:0]] = 1'b1;
      end else if ((atrr_pkg::TurnW+1)'(rem) > upper_edge) begin
        hit[idx_next[4:0]] = 1'b1;
      end
    end
  end

  assign mask_new = accumulated_mask | hit;
  assign out_free = !out_valid || out_ready;

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      atrr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = touching ? atrr_pkg::ST_ROTATE : atrr_pkg::ST_MAP;
        end
      end
      atrr_pkg::ST_ROTATE: begin
        if (cordic_done) state_next = atrr_pkg::ST_MAP;
      end
      atrr_pkg::ST_MAP: state_next = atrr_pkg::ST_UPDATE;
      atrr_pkg::ST_UPDATE: begin
        if (!last_q || out_free) state_next = atrr_pkg::ST_IDLE;
      end
      default: state_next = atrr_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready     = 1'b0;
    cordic_start = 1'b0;
    emit         = 1'b0;
    acc_load     = 1'b0;
    unique case (state)
      atrr_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cordic_start = in_valid && touching;
      end
      atrr_pkg::ST_UPDATE: begin
        emit     = last_q && out_free;
        acc_load = !last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= atrr_pkg::ST_IDLE;
      accumulated_mask <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        accumulated_mask <= '0;
        out_valid        <= 1'b1;
      end else begin
        if (acc_load) accumulated_mask <= mask_new;
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      touching_q <= touching;
      last_q     <= last;
    end
    if (state == atrr_pkg::ST_MAP) begin
      prod <= {{atrr_pkg::ResW{1'b0}}, turn} * {{atrr_pkg::TurnW{1'b0}}, eff};
    end
    if (emit) begin
      receptor_mask <= mask_new;
    end
  end

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    cordic_start |=> state == atrr_pkg::ST_ROTATE)
    else $error("CORDIC started outside a touching request");
  a_done_in_rotate: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == atrr_pkg::ST_ROTATE)
    else $error("CORDIC result arrived outside rotation");
  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    (64'(accumulated_mask) >> EffMax) == 64'd0)
    else $error("receptor bit beyond effective count");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && accumulated_mask == '0)
    else $error("mask not cleared after emit");

endmodule

// ----- rtl/atrr_cordic.sv -----
// ----------------------------------------------------------------------------
// atrr_cordic - iterative vectoring CORDIC, point to clockwise turn from +y
// One add/shift step per cycle through the CordicN rotation steps; done pulses when turn is valid.
// ----------------------------------------------------------------------------
module atrr_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [atrr_pkg::CoordW-1:0] x,
  input  logic signed [atrr_pkg::CoordW-1:0] y,
  output logic                              done,
  output logic [atrr_pkg::TurnW-1:0]        turn
);

  logic                                busy;
  logic [atrr_pkg::StepW-1:0]          step;
  logic signed [atrr_pkg::VecW-1:0]    u;
  logic signed [atrr_pkg::VecW-1:0]    v;
  logic signed [atrr_pkg::AngW-1:0]    z;
  logic                                origin;

  logic signed [atrr_pkg::VecW-1:0]    x_ext;
  logic signed [atrr_pkg::VecW-1:0]    y_ext;
  logic signed [atrr_pkg::VecW-1:0]    du;
  logic signed [atrr_pkg::VecW-1:0]    dv;
  logic signed [atrr_pkg::AngW-1:0]    da;

  assign x_ext = atrr_pkg::VecW'(x);
  assign y_ext = atrr_pkg::VecW'(y);
  assign du    = v >>> step;
  assign dv    = u >>> step;
  assign da    = signed'({{(atrr_pkg::AngW-atrr_pkg::AtanW){1'b0}},
                          atrr_pkg::atan_turn(step)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == atrr_pkg::StepW'(atrr_pkg::CordicN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      origin <= (x == '0) && (y == '0);
      if (y < 0) begin
        u <= -y_ext;
        v <= -x_ext;
        z <= atrr_pkg::HALF_TURN;
      end else begin
        u <= y_ext;
        v <= x_ext;
        z <= '0;
      end
    end else if (busy) begin
      if (v >= 0) begin
        u <= u + du;
        v <= v - dv;
        z <= z + da;
      end else begin
        u <= u - du;
        v <= v + dv;
        z <= z - da;
      end
    end
  end

  assign turn = origin ? '0 : z[atrr_pkg::TurnW-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("CORDIC restarted while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && $past(step) == atrr_pkg::StepW'(atrr_pkg::CordicN - 1))
    else $error("CORDIC done without full step count");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("CORDIC done while still busy");

endmodule

// ----- test/angular_touch_receptor_ring_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_touch_receptor_ring_test - self-checking bench for the receptor ring
// Drives contact lists through the request channel and recomputes each
// receptor mask with an in-bench CORDIC angle and receptor mapper. Masks are
// checked in order. Resolution and tolerance are swept, including the
// saturating and zero cases. The sender and receiver idle at random, and one
// long receiver hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------
module angular_touch_receptor_ring_test;

  localparam int          RING_MAX    = 32;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE_GAP  = 30;  // room for a trailing touching contact to finish
  localparam int          HOLD_LEN    = 300;

  // atan(2^-i) in 1/65536 turn, one entry per rotation step
  localparam int ARCTAN_STEP [atrr_pkg::CordicN] =
    '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [atrr_pkg::CfgIdxW-1:0]        cfg_index = '0;
  logic [atrr_pkg::CfgDataW-1:0]       cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                touching = 1'b0;
  logic signed [atrr_pkg::CoordW-1:0]  point_x = '0;
  logic signed [atrr_pkg::CoordW-1:0]  point_y = '0;
  logic                                last = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [atrr_pkg::MaskW-1:0]          receptor_mask;

  // Bench copy of the block's registers and accumulated mask
  logic [atrr_pkg::ResW-1:0]           ring_resolution = atrr_pkg::RES_RESET;
  logic [atrr_pkg::TolW-1:0]           ring_tolerance  = atrr_pkg::TOL_RESET;
  logic [atrr_pkg::MaskW-1:0]          touched_mask    = '0;
  logic [atrr_pkg::MaskW-1:0]          expected_masks[$];

  int unsigned               sender_idle_pct    = 0;
  int unsigned               receiver_stall_pct = 0;
  int unsigned               hold_off_cycles    = 0;
  int unsigned               contacts_sent      = 0;
  int unsigned               lists_checked      = 0;
  int unsigned               mismatches         = 0;
  int unsigned               cycle_count        = 0;

  angular_touch_receptor_ring #(
    .MAX_RECEPTORS(RING_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .touching     (touching),
    .point_x      (point_x),
    .point_y      (point_y),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .receptor_mask(receptor_mask)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("angular_touch_receptor_ring_test NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clockwise angle from +y as a turn fraction. Vectors below the x axis are
  // flipped by half a turn first so the 16 rotations converge.
  function automatic logic [atrr_pkg::TurnW-1:0] contact_turn(
      input logic signed [atrr_pkg::CoordW-1:0] x,
      input logic signed [atrr_pkg::CoordW-1:0] y);
    int u;
    int v;
    int z;
    int du;
    int dv;
    u = y;
    v = x;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (u < 0) begin
      u = -u;
      v = -v;
      z = 32768;
    end
    for (int i = 0; i < atrr_pkg::CordicN; i++) begin
      du = v >>> i;  // floor shift on signed int
      dv = u >>> i;
      if (v >= 0) begin
        u += du;
        v -= dv;
        z += ARCTAN_STEP[i];
      end else begin
        u -= du;
        v += dv;
        z -= ARCTAN_STEP[i];
      end
    end
    return z[atrr_pkg::TurnW-1:0];
  endfunction

  // Fold one accepted contact into the bench mask; a last contact queues it.
  function automatic void apply_contact(input logic touch,
                                        input logic signed [atrr_pkg::CoordW-1:0] x,
                                        input logic signed [atrr_pkg::CoordW-1:0] y,
                                        input logic is_last);
    int unsigned slices;
    int unsigned prod;
    int unsigned idx;
    int unsigned rem;
    int unsigned tol;
    if (touch) begin
      slices = ring_resolution;
      if (slices < 1) slices = 1;  // zero acts as one receptor
      if (slices > RING_MAX) slices = RING_MAX;
      if (slices > atrr_pkg::MaskW) slices = atrr_pkg::MaskW;
      prod = contact_turn(x, y) * slices;
      idx  = (prod >> 16) % slices;
      rem  = prod & 32'hFFFF;
      tol  = ring_tolerance;
      touched_mask[idx] = 1'b1;
      // near the low edge of a slice the previous receptor fires too,
      // near the high edge the next one
      if (rem < tol)
        touched_mask[(idx + slices - 1) % slices] = 1'b1;
      else if (rem > 65536 - tol)
        touched_mask[(idx + 1) % slices] = 1'b1;
    end
    if (is_last) begin
      expected_masks.push_back(touched_mask);
      touched_mask = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Valid is only dropped when a gap follows, so back-to-back requests keep it
  // high without a second assignment in the same step.
  task automatic send_contact(input logic touch,
                              input logic signed [atrr_pkg::CoordW-1:0] x,
                              input logic signed [atrr_pkg::CoordW-1:0] y,
                              input logic is_last);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    touching <= touch;
    point_x  <= x;
    point_y  <= y;
    last     <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_contact(touch, x, y, is_last);
    contacts_sent++;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Result checker: every accepted mask against the oldest expectation
  always @(posedge clk) begin
    logic [atrr_pkg::MaskW-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_masks.size() == 0) begin
        $display("%0t: unexpected receptor_mask expected none got %h", $time, receptor_mask);
        mismatches++;
      end else begin
        want = expected_masks.pop_front();
        lists_checked++;
        if (receptor_mask !== want) begin
          $display("%0t: receptor_mask expected %h got %h", $time, want, receptor_mask);
          mismatches++;
        end
      end
    end
  end

  // Quiet the input and let every outstanding list drain, plus time for a
  // trailing non-last contact still in the CORDIC.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Writes the resolution register, then the tolerance register; call only when idle.
  task automatic set_config(input logic [atrr_pkg::ResW-1:0] res,
                            input logic [atrr_pkg::TolW-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_index <= atrr_pkg::REG_RESOLUTION;
    cfg_data  <= atrr_pkg::CfgDataW'(res);
    @(posedge clk);
    cfg_index <= atrr_pkg::REG_TOLERANCE;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    ring_resolution = res;
    ring_tolerance  = tol;
  endtask

  function automatic logic signed [atrr_pkg::CoordW-1:0] pick_coord();
    logic signed [atrr_pkg::CoordW-1:0] c;
    case ($urandom_range(4))
      0:       c = 16'(int'($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(4))
          0:       c = 16'sh7FFF;
          1:       c = -16'sh8000;
          2:       c = 16'sh0000;
          3:       c = 16'sh0001;
          default: c = -16'sh0001;
        endcase
      end
      2:       c = 16'(int'($urandom_range(4095)) - 2048);
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers (8 receptors, tolerance 3277): axes, corners, origin,
  // and lists with non-touching contacts.
  task automatic test_directed_points();
    send_contact(1'b1, 16'sh0000, 16'sh0000, 1'b1);  // origin is angle zero
    send_contact(1'b1, 16'sh0000, 16'sh7FFF, 1'b1);
    send_contact(1'b1, 16'sh7FFF, 16'sh0000, 1'b1);
    send_contact(1'b1, 16'sh0000, -16'sh8000, 1'b1); // exactly half a turn
    send_contact(1'b1, -16'sh8000, 16'sh0000, 1'b1);
    send_contact(1'b1, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_contact(1'b1, -16'sh8000, -16'sh8000, 1'b0);
    send_contact(1'b1, -16'sh8000, 16'sh7FFF, 1'b0);
    send_contact(1'b1, 16'sh7FFF, -16'sh8000, 1'b1);
    send_contact(1'b1, -16'sh0001, -16'sh0001, 1'b1);
    send_contact(1'b1, 16'sh0001, -16'sh0001, 1'b1);
    send_contact(1'b1, -16'sh0001, 16'sh0000, 1'b1);
    send_contact(1'b1, 16'sh0000, -16'sh0001, 1'b1);
    send_contact(1'b0, 16'sh1234, 16'sh5678, 1'b1);  // empty list still emits
    send_contact(1'b1, 16'sh0100, 16'sh0000, 1'b0);
    send_contact(1'b0, 16'sh0005, 16'sh0005, 1'b0);  // ignored contact
    send_contact(1'b0, -16'sh4000, 16'sh0007, 1'b1); // last, but not touching
    send_contact(1'b1, 16'sh5555, -16'sh2AAA, 1'b0);
    send_contact(1'b1, -16'sh2AAA, 16'sh5555, 1'b1);
    settle();
  endtask

  // Zero, one, two, full and saturating resolutions
  task automatic test_resolution_extremes();
    logic [atrr_pkg::ResW-1:0] res_list [6] = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33, 6'd63};
    foreach (res_list[r]) begin
      set_config(res_list[r], atrr_pkg::TOL_RESET);
      for (int k = 0; k < 6; k++) send_contact(1'b1, pick_coord(), pick_coord(), 1'b1);
      for (int k = 0; k < 4; k++) send_contact(1'b1, pick_coord(), pick_coord(), k == 3);
      settle();
    end
  endtask

  // Tolerance zero disables neighbors; the maximum widens both edges to
  // nearly half a slice.
  task automatic test_tolerance_extremes();
    logic [atrr_pkg::TolW-1:0] tol_list [3] = '{15'd0, 15'd32767, 15'd1};
    foreach (tol_list[t]) begin
      set_config(6'd7, tol_list[t]);
      for (int k = 0; k < 10; k++) send_contact(1'b1, pick_coord(), pick_coord(), 1'b1);
      settle();
    end
  endtask

  // Random contact lists under one idle/stall setting
  task automatic test_random_lists(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [atrr_pkg::ResW-1:0] res,
                                   input logic [atrr_pkg::TolW-1:0] tol,
                                   input int unsigned n_items);
    int unsigned target;
    int unsigned len;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    set_config(res, tol);
    target = contacts_sent + n_items;
    while (contacts_sent < target) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(5, 1) : $urandom_range(12, 6);
      for (int k = 0; k < len; k++)
        send_contact($urandom_range(99) < 85, pick_coord(), pick_coord(), k == len - 1);
    end
    settle();
  endtask

  // Receiver holds off while the sender keeps pushing single-contact lists:
  // one mask parks in the output register, the next stalls the update, and
  // the request channel backs up.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    set_config(6'd16, 15'd2000);
    hold_off_cycles = HOLD_LEN;
    for (int k = 0; k < 16; k++) send_contact(1'b1, pick_coord(), pick_coord(), 1'b1);
    for (int k = 0; k < 8; k++) send_contact(1'($urandom_range(1)), pick_coord(),
                                             pick_coord(), k[0]);
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_points();
    test_resolution_extremes();
    test_tolerance_extremes();
    test_random_lists(0,  0,  6'd5,  15'($urandom_range(32767)), 180);
    test_random_lists(59, 0,  6'd32, 15'($urandom_range(4000)),  180);
    test_random_lists(0,  59, 6'd1,  15'($urandom_range(32767)), 180);
    test_random_lists(24, 24, 6'($urandom_range(31, 2)), 15'($urandom_range(32767)), 180);
    test_backpressure();

    if (expected_masks.size() != 0) begin
      $display("%0t: %0d receptor masks never arrived", $time, expected_masks.size());
      mismatches++;
    end

    $display("Ran %0d contacts, %0d masks checked, %0d mismatches.",
             contacts_sent, lists_checked, mismatches);
    $display("Swept resolution 0..63 and tolerance 0..32767 under idle, stall and hold-off.");
    if (mismatches == 0) begin
      $display("angular_touch_receptor_ring_test OK");
    end else begin
      $display("angular_touch_receptor_ring_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/atrr_pkg.sv
rtl/atrr_cordic.sv
rtl/angular_touch_receptor_ring.sv
test/angular_touch_receptor_ring_test.sv
